// ----- hdl/dspa_pkg.sv -----
// Shared types and constants for the slot phase adjuster.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package dspa_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_CYCLE  = 2'd0;
  localparam logic [1:0] CFG_FAIR   = 2'd1;
  localparam logic [1:0] CFG_MARGIN = 2'd2;

  localparam logic [15:0] CYCLE_RESET  = 16'd256;
  localparam logic [15:0] FAIR_RESET   = 16'd64;
  localparam logic [15:0] MARGIN_RESET = 16'd6;
  localparam logic [15:0] MIN_CYCLE    = 16'd2;

  localparam int          FINE_SHIFT = 8;      // fine ticks per slot tick is 2**8
  localparam logic [9:0]  DELAY_BIAS = 10'd1;

  // item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_RECV = 1'b1;

  // dividend select for the shared modulo unit
  localparam logic [2:0] MSEL_FIRE   = 3'd0;
  localparam logic [2:0] MSEL_DELAY  = 3'd1;
  localparam logic [2:0] MSEL_NOW    = 3'd2;
  localparam logic [2:0] MSEL_PHASE  = 3'd3;
  localparam logic [2:0] MSEL_TARGET = 3'd4;
  localparam logic [2:0] MSEL_ADJ    = 3'd5;

  // arithmetic steps, each done in one controller state
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_RECV  = 3'd1;
  localparam logic [2:0] OP_NEXT  = 3'd2;
  localparam logic [2:0] OP_SPACE = 3'd3;
  localparam logic [2:0] OP_APPLY = 3'd4;

  typedef struct packed {
    logic       accept;
    logic       mod_run;
    logic [2:0] mod_sel;
    logic [2:0] op;
    logic       out_load;
  } dspa_cmd_t;

  typedef struct packed {
    logic kind;
    logic cd_low;
    logic mod_done;
    logic space_ok;
    logic out_free;
  } dspa_status_t;

endpackage

// ----- hdl/desync_slot_phase_adjuster.sv -----
// Slot phase adjuster. A non-expiring tick goes straight to the result state; an expiring tick
// runs the fire pass; a receive runs the delay, now, phase, target and, if adjusting, adjustment
// passes on the shared D-bit serial modulo unit by the cycle length, D = max(TIME_BITS, 18).
// One item at a time; a new item is taken while the previous result waits in the output register.
// Synchronous reset restores register defaults (cycle 256, fair share 64, margin 6),
// clears time and phase and loads the countdown with 256; no clearing pass.
// Depends on dspa_pkg, dspa_ctrl, dspa_datapath.
`timescale 1ns / 1ps

module desync_slot_phase_adjuster #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [15:0] sent_delay,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        fired,
  output logic        adjusted,
  output logic [15:0] backoff,
  output logic [15:0] phase,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dspa_pkg::dspa_cmd_t    cmd;
  dspa_pkg::dspa_status_t status;

  // configuration transfers complete at once
  assign cfg_ready = 1'b1;

  dspa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dspa_datapath #(.TIME_BITS(TIME_BITS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .kind       (kind),
    .sent_delay (sent_delay),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .fired      (fired),
    .adjusted   (adjusted),
    .backoff    (backoff),
    .phase      (phase)
  );

endmodule

// ----- hdl/dspa_mod.sv -----
// Iterative restoring modulo unit: one dividend bit per cycle.
// Standalone; instantiated by the datapath.
`timescale 1ns / 1ps

module dspa_mod #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          run,
  input  logic [DW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic          done,
  output logic [15:0]   rem
);

  localparam int CW = $clog2(DW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] sh;
  logic [15:0]   r;
  logic [16:0]   trial;
  logic [16:0]   diff;
  logic [15:0]   r_step;
  logic          start;

  assign start  = run && !busy && !done;
  assign trial  = {r, sh[DW-1]};
  assign diff   = trial - {1'b0, divisor};
  assign r_step = (trial >= {1'b0, divisor}) ? diff[15:0] : trial[15:0];
  assign rem    = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= dividend;
      r  <= '0;
    end else if (busy) begin
      sh <= sh << 1;
      r  <= r_step;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("modulo result flagged while still iterating");

endmodule

// ----- hdl/dspa_datapath.sv -----
// Datapath: configuration, time/countdown/phase state, receive arithmetic, output register.
// Depends on dspa_pkg and dspa_mod.
`timescale 1ns / 1ps

module dspa_datapath #(
  parameter int TIME_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dspa_pkg::dspa_cmd_t     cmd,
  output dspa_pkg::dspa_status_t  status,
  input  logic                    kind,
  input  logic [15:0]             sent_delay,
  input  logic                    cfg_valid,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    fired,
  output logic                    adjusted,
  output logic [15:0]             backoff,
  output logic [15:0]             phase
);

  localparam int DW = (TIME_BITS > 18) ? TIME_BITS : 18;

  logic [15:0]          cycle_length;
  logic [15:0]          share_gap;
  logic [15:0]          delay_margin;
  logic [TIME_BITS-1:0] tick_time;
  logic [15:0]          countdown;
  logic [15:0]          own_phase;

  logic        kind_q;
  logic [9:0]  delay_q;
  logic [15:0] dmod;
  logic [15:0] now;
  logic [15:0] nxt_phase;
  logic [15:0] recv;
  logic [15:0] target;
  logic [16:0] half;
  logic [15:0] adj;
  logic        fired_r;
  logic        adjusted_r;
  logic [15:0] backoff_r;

  logic [15:0]   c_eff;
  logic [16:0]   delay_sum;
  logic [9:0]    delay_v;
  logic [16:0]   tgt_sum;
  logic [17:0]   adj_sum;
  logic [16:0]   recv_sum;
  logic [15:0]   recv_v;
  logic [16:0]   wrap_sum;
  logic [16:0]   space_sum;
  logic [15:0]   space;
  logic [17:0]   half_sum;
  logic [16:0]   apply_sum;
  logic [15:0]   apply_v;
  logic [DW-1:0] dividend;
  logic          mod_done;
  logic [15:0]   mod_rem;
  logic          cd_low;
  logic          take_in;

  assign c_eff     = (cycle_length < dspa_pkg::MIN_CYCLE) ? dspa_pkg::MIN_CYCLE : cycle_length;
  assign cd_low    = countdown <= 16'd1;
  assign take_in   = cmd.accept;

  assign delay_sum = {1'b0, sent_delay} + {1'b0, delay_margin};
  assign delay_v   = 10'(delay_sum >> dspa_pkg::FINE_SHIFT) + dspa_pkg::DELAY_BIAS;

  assign tgt_sum   = {1'b0, recv} + {1'b0, share_gap};
  assign adj_sum   = {1'b0, half} + {1'b0, c_eff, 1'b0} - {2'b00, recv} - {2'b00, dmod};

  // neighbour phase: now - dmod, folded back into the cycle
  assign recv_sum  = {1'b0, now} + {1'b0, c_eff} - {1'b0, dmod};
  assign recv_v    = (recv_sum >= {1'b0, c_eff}) ? 16'(recv_sum - {1'b0, c_eff})
                                                 : recv_sum[15:0];
  assign wrap_sum  = {1'b0, nxt_phase} + {1'b0, c_eff} - {1'b0, recv};

  assign space_sum = {1'b0, nxt_phase} + {1'b0, c_eff} - {1'b0, recv};
  assign space     = (space_sum >= {1'b0, c_eff}) ? 16'(space_sum - {1'b0, c_eff})
                                                  : space_sum[15:0];
  // midpoint toward the target, going around the cycle when the target lies behind
  assign half_sum  = {2'b00, nxt_phase} + {2'b00, target}
                   + ((target >= nxt_phase) ? 18'd0 : {2'b00, c_eff});

  assign apply_sum = {1'b0, now} + {1'b0, adj};
  assign apply_v   = (apply_sum >= {1'b0, c_eff}) ? 16'(apply_sum - {1'b0, c_eff})
                                                  : apply_sum[15:0];

  always_comb begin
    unique case (cmd.mod_sel) inside
      dspa_pkg::MSEL_FIRE,
      dspa_pkg::MSEL_NOW:    dividend = DW'(tick_time);
      dspa_pkg::MSEL_DELAY:  dividend = DW'(delay_q);
      dspa_pkg::MSEL_PHASE:  dividend = DW'(own_phase);
      dspa_pkg::MSEL_TARGET: dividend = DW'(tgt_sum);
      dspa_pkg::MSEL_ADJ:    dividend = DW'(adj_sum);
      default:               dividend = '0;
    endcase
  end

  dspa_mod #(.DW(DW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .run      (cmd.mod_run),
    .dividend (dividend),
    .divisor  (c_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign status.kind     = kind;
  assign status.cd_low   = cd_low;
  assign status.mod_done = mod_done;
  assign status.space_ok = space < share_gap;
  assign status.out_free = !out_valid || out_ready;

  // architectural state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_length <= dspa_pkg::CYCLE_RESET;
      share_gap    <= dspa_pkg::FAIR_RESET;
      delay_margin <= dspa_pkg::MARGIN_RESET;
      tick_time    <= '0;
      countdown    <= dspa_pkg::CYCLE_RESET;
      own_phase    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          dspa_pkg::CFG_CYCLE:  cycle_length <= cfg_data;
          dspa_pkg::CFG_FAIR:   share_gap    <= cfg_data;
          dspa_pkg::CFG_MARGIN: delay_margin <= cfg_data;
          default: ;
        endcase
      end
      if (take_in && kind == dspa_pkg::KIND_TICK) begin
        tick_time <= tick_time + TIME_BITS'(1);
        // expire: reload a full cycle, phase follows from the modulo pass
        countdown <= cd_low ? cycle_length : countdown - 16'd1;
      end
      if (mod_done && cmd.mod_sel == dspa_pkg::MSEL_FIRE) begin
        own_phase <= mod_rem;
      end
      if (cmd.op == dspa_pkg::OP_APPLY) begin
        own_phase <= apply_v;
        countdown <= adj;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    if (take_in) begin
      kind_q     <= kind;
      delay_q    <= delay_v;
      fired_r    <= (kind == dspa_pkg::KIND_TICK) && cd_low;
      adjusted_r <= 1'b0;
      backoff_r  <= '0;
    end
    if (mod_done) begin
      unique case (cmd.mod_sel)
        dspa_pkg::MSEL_DELAY:  dmod      <= mod_rem;
        dspa_pkg::MSEL_NOW:    now       <= mod_rem;
        dspa_pkg::MSEL_PHASE:  nxt_phase <= mod_rem;
        dspa_pkg::MSEL_TARGET: target    <= mod_rem;
        dspa_pkg::MSEL_ADJ:    adj       <= mod_rem;
        default: ;
      endcase
    end
    unique case (cmd.op)
      dspa_pkg::OP_RECV: recv <= recv_v;
      dspa_pkg::OP_NEXT: begin
        if (nxt_phase < recv) begin
          nxt_phase <= wrap_sum[15:0];
          recv      <= '0;
        end
      end
      dspa_pkg::OP_SPACE: half <= half_sum[17:1];
      dspa_pkg::OP_APPLY: begin
        adjusted_r <= 1'b1;
        backoff_r  <= adj;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      fired    <= fired_r && (kind_q == dspa_pkg::KIND_TICK);
      adjusted <= adjusted_r;
      backoff  <= backoff_r;
      phase    <= own_phase;
    end
  end

endmodule

// ----- hdl/dspa_ctrl.sv -----
// Controller: sequences one item through the modulo passes and arithmetic steps.
// Depends on dspa_pkg.
`timescale 1ns / 1ps

module dspa_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dspa_pkg::dspa_status_t status,
  output dspa_pkg::dspa_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TMOD  = 4'd1;
  localparam logic [3:0] S_DMOD  = 4'd2;
  localparam logic [3:0] S_NMOD  = 4'd3;
  localparam logic [3:0] S_PMOD  = 4'd4;
  localparam logic [3:0] S_RECV  = 4'd5;
  localparam logic [3:0] S_NEXT  = 4'd6;
  localparam logic [3:0] S_GMOD  = 4'd7;
  localparam logic [3:0] S_SPACE = 4'd8;
  localparam logic [3:0] S_AMOD  = 4'd9;
  localparam logic [3:0] S_APPLY = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.mod_run  = 1'b0;
    cmd.mod_sel  = dspa_pkg::MSEL_FIRE;
    cmd.op       = dspa_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.kind == dspa_pkg::KIND_RECV) begin
            state_next = S_DMOD;
          end else if (status.cd_low) begin
            state_next = S_TMOD;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_TMOD: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = dspa_pkg::MSEL_FIRE;
        if (status.mod_done) state_next = S_FIN;
      end
      S_DMOD: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = dspa_pkg::MSEL_DELAY;
        if (status.mod_done) state_next = S_NMOD;
      end
      S_NMOD: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = dspa_pkg::MSEL_NOW;
        if (status.mod_done) state_next = S_PMOD;
      end
      S_PMOD: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = dspa_pkg::MSEL_PHASE;
        if (status.mod_done) state_next = S_RECV;
      end
      S_RECV: begin
        cmd.op     = dspa_pkg::OP_RECV;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        cmd.op     = dspa_pkg::OP_NEXT;
        state_next = S_GMOD;
      end
      S_GMOD: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = dspa_pkg::MSEL_TARGET;
        if (status.mod_done) state_next = S_SPACE;
      end
      S_SPACE: begin
        cmd.op     = dspa_pkg::OP_SPACE;
        // drop the adjustment when the gap is already wide enough
        state_next = status.space_ok ? S_AMOD : S_FIN;
      end
      S_AMOD: begin
        cmd.mod_run = 1'b1;
        cmd.mod_sel = dspa_pkg::MSEL_ADJ;
        if (status.mod_done) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.op     = dspa_pkg::OP_APPLY;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an untaken result");

  a_plain_tick: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && status.kind == dspa_pkg::KIND_TICK && !status.cd_low)
    |=> state == S_FIN)
    else $error("non-expiring tick did not go straight to result");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    status.mod_done |-> cmd.mod_run)
    else $error("modulo result arrived outside a modulo pass");

endmodule
